// ----- design/bdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants of the branch direction chooser
// Holds the policy codes, register indexes, direction codes and the
// configuration struct passed from the register file to the datapath.
// ----------------------------------------------------------------------------
package bdc_pkg;

    // Width of the configuration data and of the pruning limits.
    localparam int CFG_W     = 24;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 8;
    // Width of the result tdata (one direction bit padded to a byte).
    localparam int OUT_W     = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_NODE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_BEST = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BEST = 8'd3;

    // Reset values of the limit registers.
    localparam logic [CFG_W-1:0] BEST_RESET = 24'hFFFFFF;

    // Branching direction codes.
    localparam logic DIR_BEGIN = 1'b0;
    localparam logic DIR_END   = 1'b1;

    // Decision policy.
    typedef enum logic [1:0] {
        MODE_BEGIN  = 2'd0,
        MODE_SUM    = 2'd1,
        MODE_PRUNED = 2'd2,
        MODE_MIN    = 2'd3
    } mode_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        mode_t            mode;
        logic             single_node;
        logic [CFG_W-1:0] current_best;
        logic [CFG_W-1:0] initial_best;
    } cfg_t;

endpackage

// ----- design/bdc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bdc_cfg_regs: configuration register file
// Takes register writes by index and presents the policy and limits as one
// struct. Writes to indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module bdc_cfg_regs
    import bdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // The register file can always take a write.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_BEGIN;
            cfg_reg.single_node  <= 1'b1;
            cfg_reg.current_best <= BEST_RESET;
            cfg_reg.initial_best <= BEST_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:         cfg_reg.mode         <= mode_t'(cfg_data[1:0]);
                REG_SINGLE_NODE:  cfg_reg.single_node  <= cfg_data[0];
                REG_CURRENT_BEST: cfg_reg.current_best <= cfg_data;
                REG_INITIAL_BEST: cfg_reg.initial_best <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule

// ----- design/bdc_in_stage.sv -----
// ----------------------------------------------------------------------------
// bdc_in_stage: input register
// Captures one bound pair per cycle while not stalled; holds it until the
// accumulator takes it. It refills in the same cycle that its item moves on.
// ----------------------------------------------------------------------------
module bdc_in_stage
    import bdc_pkg::*;
#(
    parameter int COST_BITS = 24,
    parameter int DATA_W    = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  logic                 advance,
    output logic                 item_valid,
    output logic [COST_BITS-1:0] cost_front,
    output logic [COST_BITS-1:0] cost_back,
    output logic                 is_last
);

    logic                 valid_reg;
    logic [COST_BITS-1:0] front_reg;
    logic [COST_BITS-1:0] back_reg;
    logic                 last_reg;
    logic                 load;

    // Ready when empty or when the held item leaves this cycle.
    assign s_axis_tready = !valid_reg || advance;
    assign load          = s_axis_tvalid && s_axis_tready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_reg <= s_axis_tdata[COST_BITS-1:0];
            back_reg  <= s_axis_tdata[2*COST_BITS-1:COST_BITS];
            last_reg  <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign cost_front = front_reg;
    assign cost_back  = back_reg;
    assign is_last    = last_reg;

endmodule

// ----- design/bdc_accum.sv -----
// ----------------------------------------------------------------------------
// bdc_accum: decision accumulator
// Folds one bound pair per cycle while advance is high into the running sums,
// the pruned balance and the minimum tracker, and on the last pair of a
// decision computes the direction from the updated state and clears the state.
// ----------------------------------------------------------------------------
module bdc_accum
    import bdc_pkg::*;
#(
    parameter int COST_BITS = 24,
    parameter int BAL_W     = 12,
    parameter int SUM_W     = 36
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 advance,
    input  logic [COST_BITS-1:0] cost_front,
    input  logic [COST_BITS-1:0] cost_back,
    input  logic                 is_last,
    output logic                 direction
);

    localparam int CMP_W = (COST_BITS > CFG_W) ? COST_BITS : CFG_W;
    localparam int MIN_W = COST_BITS + 1;
    localparam logic [MIN_W-1:0] MIN_RESET = {1'b1, {COST_BITS{1'b0}}};

    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] total_next;
    logic [SUM_W-1:0] open_reg;
    logic [SUM_W-1:0] open_next;
    logic [BAL_W-1:0] pruned_reg;
    logic [BAL_W-1:0] pruned_next;
    logic [MIN_W-1:0] minimum_reg;
    logic [MIN_W-1:0] minimum_next;
    logic [BAL_W-1:0] min_bal_reg;
    logic [BAL_W-1:0] min_bal_next;

    logic [CFG_W-1:0] limit;
    logic             prune_front;
    logic             prune_back;
    logic [SUM_W-1:0] open_add;
    logic [SUM_W-1:0] open_sub;
    logic [MIN_W-1:0] front_ext;
    logic [MIN_W-1:0] back_ext;
    logic             front_new_min;
    logic             back_new_min;
    logic [MIN_W-1:0] min_after_front;
    logic [BAL_W-1:0] bal_after_front;
    logic [BAL_W-1:0] bal_reset_front;
    logic [BAL_W-1:0] bal_reset_back;

    // Sums and pruning against the selected limit.
    always_comb
    begin
        limit       = cfg.single_node ? cfg.current_best : cfg.initial_best;
        prune_front = CMP_W'(cost_front) >= CMP_W'(limit);
        prune_back  = CMP_W'(cost_back) >= CMP_W'(limit);
        open_add    = prune_front ? '0 : SUM_W'(cost_front);
        open_sub    = prune_back ? '0 : SUM_W'(cost_back);
        total_next  = total_reg + SUM_W'(cost_front) - SUM_W'(cost_back);
        open_next   = open_reg + open_add - open_sub;
        pruned_next = pruned_reg + BAL_W'(prune_front) - BAL_W'(prune_back);
    end

    // Minimum tracker: front bound first, then back bound.
    always_comb
    begin
        front_ext       = MIN_W'(cost_front);
        back_ext        = MIN_W'(cost_back);
        front_new_min   = (cost_front != '0) && (front_ext < minimum_reg);
        min_after_front = front_new_min ? front_ext : minimum_reg;
        bal_reset_front = front_new_min ? '0 : min_bal_reg;
        bal_after_front = (front_ext == min_after_front) ?
                          bal_reset_front + BAL_W'(1) : bal_reset_front;
        back_new_min    = (cost_back != '0) && (back_ext < min_after_front);
        minimum_next    = back_new_min ? back_ext : min_after_front;
        bal_reset_back  = back_new_min ? '0 : bal_after_front;
        min_bal_next    = (back_ext == minimum_next) ?
                          bal_reset_back - BAL_W'(1) : bal_reset_back;
    end

    // Direction from the state including the last pair.
    always_comb
    begin
        case (cfg.mode)
            MODE_SUM:
            begin
                direction = total_next[SUM_W-1] ? DIR_END : DIR_BEGIN;
            end
            MODE_PRUNED:
            begin
                if (pruned_next != '0)
                    direction = pruned_next[BAL_W-1] ? DIR_END : DIR_BEGIN;
                else
                    direction = open_next[SUM_W-1] ? DIR_END : DIR_BEGIN;
            end
            MODE_MIN:
            begin
                if (min_bal_next != '0)
                    direction = min_bal_next[BAL_W-1] ? DIR_BEGIN : DIR_END;
                else if ((pruned_next != '0) && !pruned_next[BAL_W-1])
                    direction = DIR_BEGIN;
                else
                    direction = DIR_END;
            end
            default:
            begin
                direction = DIR_BEGIN;
            end
        endcase
    end

    // State registers; the last pair of a decision clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            open_reg    <= '0;
            pruned_reg  <= '0;
            minimum_reg <= MIN_RESET;
            min_bal_reg <= '0;
        end
        else if (advance)
        begin
            if (is_last)
            begin
                total_reg   <= '0;
                open_reg    <= '0;
                pruned_reg  <= '0;
                minimum_reg <= MIN_RESET;
                min_bal_reg <= '0;
            end
            else
            begin
                total_reg   <= total_next;
                open_reg    <= open_next;
                pruned_reg  <= pruned_next;
                minimum_reg <= minimum_next;
                min_bal_reg <= min_bal_next;
            end
        end
    end

endmodule

// ----- design/bdc_out_reg.sv -----
// ----------------------------------------------------------------------------
// bdc_out_reg: result register
// Holds one direction item until the consumer takes it. A new result may
// load in the same cycle that the held one is taken.
// ----------------------------------------------------------------------------
module bdc_out_reg
    import bdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             direction,
    output logic             free,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic valid_reg;
    logic dir_reg;

    assign free = !valid_reg || m_axis_tready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dir_reg <= direction;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, dir_reg};

endmodule

// ----- design/branch_direction_chooser_unit.sv -----
// ----------------------------------------------------------------------------
// branch_direction_chooser_unit: branching direction for branch-and-bound
// Streams one job's pair of child bounds per item and, on the last pair of a
// decision, emits the chosen branching direction according to the policy.
// ----------------------------------------------------------------------------
// Path: a last input item passes the input register, then the result register.
// Throughput: one item per cycle while the result register takes last items.
// Non-last items produce no result; backpressure stalls only last items.
// Reset: rst_n clears configuration to its defaults and all running state.
// ----------------------------------------------------------------------------
module branch_direction_chooser_unit
    import bdc_pkg::*;
#(
    parameter int MAX_JOBS  = 1024,
    parameter int COST_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input items.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [COST_BITS-1:0] cost_front, [2*COST_BITS-1:COST_BITS] cost_back, zero pad
    input  logic [((2*COST_BITS+7)/8)*8-1:0] s_axis_tdata,
    // is_last
    input  logic                 s_axis_tlast,
    // Result items.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] direction, zero pad
    output logic [OUT_W-1:0]     m_axis_tdata,
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DATA_W = ((2*COST_BITS+7)/8)*8;
    localparam int BAL_W  = $clog2(MAX_JOBS) + 2;
    localparam int SUM_W  = COST_BITS + BAL_W;

    cfg_t                 cfg;
    logic                 item_valid;
    logic [COST_BITS-1:0] cost_front;
    logic [COST_BITS-1:0] cost_back;
    logic                 is_last;
    logic                 out_free;
    logic                 advance;
    logic                 direction;
    logic                 result_load;

    // An item moves on unless it is a last item facing a full result register.
    assign advance     = item_valid && (!is_last || out_free);
    assign result_load = advance && is_last;

    bdc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdc_in_stage #(
        .COST_BITS (COST_BITS),
        .DATA_W    (DATA_W)
    ) u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .cost_front    (cost_front),
        .cost_back     (cost_back),
        .is_last       (is_last)
    );

    bdc_accum #(
        .COST_BITS (COST_BITS),
        .BAL_W     (BAL_W),
        .SUM_W     (SUM_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .advance    (advance),
        .cost_front (cost_front),
        .cost_back  (cost_back),
        .is_last    (is_last),
        .direction  (direction)
    );

    bdc_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (result_load),
        .direction     (direction),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // A result only appears after a last item was folded in.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(result_load))
        else $error("result appeared without a last item");

    // A last item never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> out_free)
        else $error("last item advanced into a full result register");

    // A held item that does not move on is still held next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !advance) |=> item_valid)
        else $error("input item lost while stalled");
`endif

endmodule

// ----- tb/branch_direction_chooser_unit_tb.sv -----
// ----------------------------------------------------------------------------
// branch_direction_chooser_unit_tb: self-checking bench of the direction chooser
// Streams job bound pairs through the block under every policy and limit
// choice, predicts each branching direction with its own accumulator model,
// and compares every result item against the oldest predicted direction.
// Both stream sides idle at random, including a long output stall.
// ----------------------------------------------------------------------------
module branch_direction_chooser_unit_tb;
    import bdc_pkg::*;

    localparam int          COST_W      = 24;
    localparam int          IN_W        = ((2*COST_W+7)/8)*8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RANDOM_ITEMS = 900;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
    localparam logic [COST_W-1:0]    COST_MAX   = 24'hFFFFFF;

    // Directed stimulus row: a register write or one bound pair.
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     value;
        logic [COST_W-1:0]    cost_front;
        logic [COST_W-1:0]    cost_back;
        logic                 last;
        bit                   known;
        logic                 dir;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Mirror of the configuration registers.
    mode_t            mir_mode;
    logic             mir_single;
    logic [CFG_W-1:0] mir_current;
    logic [CFG_W-1:0] mir_initial;

    // Predictor state of the running decision.
    logic [35:0] sum_all;
    logic [35:0] sum_open;
    logic [11:0] prune_bal;
    logic [24:0] min_cost;
    logic [11:0] min_bal;

    logic        pending_dirs[$];
    stim_row_t   directed_rows[$];
    int          error_count;
    int unsigned cycle_count;
    int          burst_left;
    bit          no_gaps;
    bit          hold_req;
    int          random_items;
    int          row_i;
    int          phase_i;
    int          job_i;
    int          run_len;
    int          rx_seg_left;
    int          rx_style;
    logic        observed_dir;

    branch_direction_chooser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at cycle %0d: %s (got %0h, expected %0h)",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Clear the running decision state.
    function automatic void clear_decision();
        sum_all   = '0;
        sum_open  = '0;
        prune_bal = '0;
        min_cost  = 25'h1000000;
        min_bal   = '0;
    endfunction

    // Track the smallest positive bound and front hits minus back hits on it.
    function automatic void fold_minimum(input logic [COST_W-1:0] cost, input bit front);
        if (cost != '0 && {1'b0, cost} < min_cost)
        begin
            min_cost = {1'b0, cost};
            min_bal  = '0;
        end
        if ({1'b0, cost} == min_cost)
            min_bal = front ? min_bal + 12'd1 : min_bal - 12'd1;
    endfunction

    // Fold one bound pair into the decision; returns 1 when a direction is due.
    function automatic bit fold_bound_pair(input logic [COST_W-1:0] cf,
                                           input logic [COST_W-1:0] cb,
                                           input logic last, output logic dir);
        logic [CFG_W-1:0] limit;
        limit = mir_single ? mir_current : mir_initial;
        dir   = DIR_BEGIN;
        sum_all = sum_all + {12'd0, cf} - {12'd0, cb};
        if (cf >= limit)
            prune_bal = prune_bal + 12'd1;
        else
            sum_open = sum_open + {12'd0, cf};
        if (cb >= limit)
            prune_bal = prune_bal - 12'd1;
        else
            sum_open = sum_open - {12'd0, cb};
        fold_minimum(cf, 1'b1);
        fold_minimum(cb, 1'b0);
        if (!last)
            return 1'b0;
        case (mir_mode)
            MODE_SUM:
                dir = sum_all[35] ? DIR_END : DIR_BEGIN;
            MODE_PRUNED:
                if (prune_bal != '0)
                    dir = prune_bal[11] ? DIR_END : DIR_BEGIN;
                else
                    dir = sum_open[35] ? DIR_END : DIR_BEGIN;
            MODE_MIN:
                if (min_bal != '0)
                    dir = min_bal[11] ? DIR_BEGIN : DIR_END;
                else
                    dir = (prune_bal != '0 && !prune_bal[11]) ? DIR_BEGIN : DIR_END;
            default:
                dir = DIR_BEGIN;
        endcase
        clear_decision();
        return 1'b1;
    endfunction

    // Directed row builders.
    function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] value);
        stim_row_t row;
        row = '{1'b1, idx, value, '0, '0, 1'b0, 1'b0, DIR_BEGIN};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_pair_row(input logic [COST_W-1:0] cf,
                                         input logic [COST_W-1:0] cb,
                                         input logic last);
        stim_row_t row;
        row = '{1'b0, '0, '0, cf, cb, last, 1'b0, DIR_BEGIN};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_known_row(input logic [COST_W-1:0] cf,
                                          input logic [COST_W-1:0] cb,
                                          input logic dir);
        stim_row_t row;
        row = '{1'b0, '0, '0, cf, cb, 1'b1, 1'b1, dir};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Random pruning limit, with the extremes weighted in.
    function automatic logic [CFG_W-1:0] pick_limit();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        else if (k == 1)
            return BEST_RESET;
        else if (k < 6)
            return CFG_W'($urandom_range(0, 20));
        else
            return CFG_W'($urandom);
    endfunction

    // Random bound: small values for minimum ties, values around the limit,
    // the extremes, and the full range.
    function automatic logic [COST_W-1:0] pick_cost();
        int k;
        int t;
        k = $urandom_range(0, 9);
        if (k < 4)
            return COST_W'($urandom_range(0, 12));
        if (k < 6)
        begin
            t = int'(mir_single ? mir_current : mir_initial) + int'($urandom_range(0, 4)) - 2;
            if (t < 0)
                t = 0;
            if (t > int'(COST_MAX))
                t = int'(COST_MAX);
            return COST_W'(t);
        end
        if (k == 6)
            return $urandom_range(0, 1) ? COST_MAX : '0;
        return COST_W'($urandom);
    endfunction

    // Write one register and track it in the mirror; returns just after an edge.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        bit accepted;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = cfg_valid && cfg_ready;
            @(posedge clk);
        end
        case (idx)
            REG_MODE:         mir_mode    = mode_t'(value[1:0]);
            REG_SINGLE_NODE:  mir_single  = value[0];
            REG_CURRENT_BEST: mir_current = value;
            REG_INITIAL_BEST: mir_initial = value;
            default:          ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one bound pair in bursts with random gaps; predict on acceptance.
    task automatic send_pair(input logic [COST_W-1:0] cf, input logic [COST_W-1:0] cb,
                             input logic last, input bit known, input logic known_dir);
        bit   accepted;
        int   gap;
        logic dir;
        if (!no_gaps && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cb, cf};
        s_axis_tlast  <= last;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_axis_tvalid && s_axis_tready;
            @(posedge clk);
        end
        if (fold_bound_pair(cf, cb, last, dir))
            pending_dirs.insert(pending_dirs.size(), known ? known_dir : dir);
    endtask

    // Stop offering and wait until every predicted direction has come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_dirs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Output checker: results are sampled between edges.
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_dirs.size() == 0)
                report_mismatch("direction with no decision pending", m_axis_tdata, 8'h00);
            else
            begin
                observed_dir = pending_dirs[0];
                pending_dirs.delete(0);
                if (m_axis_tdata !== {7'd0, observed_dir})
                    report_mismatch("direction", m_axis_tdata, {7'd0, observed_dir});
            end
        end
    end

    // Receiver: segments of always ready, random ready and mostly stalled,
    // plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        rx_seg_left   = 0;
        rx_style      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                if (rx_seg_left == 0)
                begin
                    rx_seg_left = $urandom_range(5, 40);
                    rx_style    = $urandom_range(0, 2);
                end
                rx_seg_left--;
                case (rx_style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        error_count   = 0;
        cycle_count   = 0;
        burst_left    = 0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        random_items  = 0;
        mir_mode      = MODE_BEGIN;
        mir_single    = 1'b1;
        mir_current   = BEST_RESET;
        mir_initial   = BEST_RESET;
        clear_decision();

        // Reset defaults: always begin, whatever the bounds.
        add_known_row('0, '0, DIR_BEGIN);
        add_known_row(COST_MAX, COST_MAX, DIR_BEGIN);
        add_known_row(COST_MAX, '0, DIR_BEGIN);
        add_known_row('0, COST_MAX, DIR_BEGIN);
        // Summed bounds, including the tie that picks begin.
        add_cfg_row(REG_MODE, {22'd0, MODE_SUM});
        add_known_row(COST_MAX, '0, DIR_BEGIN);
        add_known_row('0, COST_MAX, DIR_END);
        add_known_row(24'd7, 24'd7, DIR_BEGIN);
        add_pair_row(24'd100, 24'd40, 1'b0);
        add_pair_row(24'd10, 24'd90, 1'b1);
        // Pruned counts against the current best, with the open-sum tie break.
        add_cfg_row(REG_MODE, {22'd0, MODE_PRUNED});
        add_cfg_row(REG_CURRENT_BEST, 24'd100);
        add_pair_row(24'd150, 24'd10, 1'b0);
        add_pair_row(24'd20, 24'd30, 1'b1);
        add_pair_row(24'd10, 24'd150, 1'b1);
        add_pair_row(24'd10, 24'd20, 1'b1);
        add_pair_row(24'd100, 24'd100, 1'b1);
        // Pruning against a zero initial best: every bound is pruned.
        add_cfg_row(REG_SINGLE_NODE, 24'd0);
        add_cfg_row(REG_INITIAL_BEST, 24'd0);
        add_pair_row(24'd1, 24'd2, 1'b1);
        // Minimum frequency; zero bounds never count as the minimum.
        add_cfg_row(REG_INITIAL_BEST, BEST_RESET);
        add_cfg_row(REG_MODE, {22'd0, MODE_MIN});
        add_known_row('0, '0, DIR_END);
        add_pair_row(24'd5, 24'd9, 1'b1);
        add_pair_row(24'd9, 24'd5, 1'b1);
        add_pair_row(24'd4, 24'd4, 1'b1);
        add_pair_row(COST_MAX, 24'd1, 1'b0);
        add_pair_row(24'd2, 24'd1, 1'b1);
        // A write to an unmapped index changes nothing.
        add_cfg_row(REG_UNUSED, COST_MAX);
        add_cfg_row(REG_INITIAL_BEST, 24'd8);
        add_pair_row(24'd4, 24'd4, 1'b0);
        add_pair_row(24'd20, 24'd5, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table.
        for (row_i = 0; row_i < directed_rows.size(); row_i++)
        begin
            if (directed_rows[row_i].is_cfg)
            begin
                wait_idle();
                cfg_write(directed_rows[row_i].idx, directed_rows[row_i].value);
            end
            else
                send_pair(directed_rows[row_i].cost_front, directed_rows[row_i].cost_back,
                          directed_rows[row_i].last, directed_rows[row_i].known,
                          directed_rows[row_i].dir);
        end

        // Random phases: new settings, then a string of decisions.
        phase_i = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            cfg_write(REG_MODE, ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                            : CFG_W'($urandom_range(0, 3)));
            cfg_write(REG_SINGLE_NODE, ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                                   : CFG_W'($urandom_range(0, 1)));
            cfg_write(REG_CURRENT_BEST, pick_limit());
            cfg_write(REG_INITIAL_BEST, pick_limit());

            // Once, flood last items into a long output stall.
            if (phase_i == 1)
            begin
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                for (job_i = 0; job_i < 60; job_i++)
                    send_pair(pick_cost(), pick_cost(), 1'b1, 1'b0, DIR_BEGIN);
                no_gaps = 1'b0;
                random_items += 60;
            end
            else
            begin
                repeat ($urandom_range(8, 20))
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: run_len = $urandom_range(1, 3);
                        5, 6, 7, 8:    run_len = $urandom_range(4, 12);
                        default:       run_len = $urandom_range(13, 40);
                    endcase
                    for (job_i = 0; job_i < run_len; job_i++)
                        send_pair(pick_cost(), pick_cost(), job_i == run_len - 1,
                                  1'b0, DIR_BEGIN);
                    random_items += run_len;
                end
            end
            phase_i++;
        end

        // Drain and settle.
        s_axis_tvalid <= 1'b0;
        while (pending_dirs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
